FILE: hw/rtl/neighbour_contrast_beta_unit_macros.svh
// ----------------------------------------------------------------------------
// neighbour contrast beta unit assertion macros
// concurrent assertion shorthands clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_CONTRAST_BETA_UNIT_MACROS_SVH
`define NEIGHBOUR_CONTRAST_BETA_UNIT_MACROS_SVH

// same-cycle implication
`define NCB_ASSERT_NOW(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication
`define NCB_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: hw/rtl/ncb_pkg.sv
// ----------------------------------------------------------------------------
// ncb_pkg
// shared widths, register indexes and state codes of the contrast unit
// ----------------------------------------------------------------------------
package ncb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int SQ_W       = 2 * CHAN_W + 2;
  localparam int SUM_W      = 40;
  localparam int PAIR_W     = 22;
  localparam int FRAC_BITS  = 39;
  localparam int BETA_W     = 62;
  localparam int NUM_W      = PAIR_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int CFG_IDX_W  = 2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_UP,
    ST_ACCUM,
    ST_PAIRS,
    ST_DIVIDE,
    ST_DELIVER
  } ncb_state_t;

  typedef enum logic [1:0] {
    NB_LEFT,
    NB_UPLEFT,
    NB_UP,
    NB_UPRIGHT
  } ncb_nb_t;

  // zero reads as one, oversize reads as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/ncb_channels.sv
// ----------------------------------------------------------------------------
// ncb channels
// valid/ready channels for pixels, results and register writes
// ----------------------------------------------------------------------------
interface ncb_pixel_if import ncb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] chan_a;
  logic [CHAN_W-1:0] chan_b;
  logic [CHAN_W-1:0] chan_c;

  modport source (output valid, output chan_a, output chan_b, output chan_c,
                  input ready);
  modport sink   (input valid, input chan_a, input chan_b, input chan_c,
                  output ready);
endinterface

interface ncb_result_if import ncb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BETA_W-1:0] beta_q;
  logic [SUM_W-1:0]  sq_sum;
  logic [PAIR_W-1:0] pair_total;
  logic              zero_contrast;

  modport source (output valid, output beta_q, output sq_sum, output pair_total,
                  output zero_contrast, input ready);
  modport sink   (input valid, input beta_q, input sq_sum, input pair_total,
                  input zero_contrast, output ready);
endinterface

interface ncb_cfg_if import ncb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/neighbour_contrast_beta_unit.sv
// ----------------------------------------------------------------------------
// neighbour_contrast_beta_unit
// frame-wide colour contrast estimate over 8-neighbour pairs of a raster frame
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, and no new pixel is taken until the last is
// done: one line-store read for the pixel above, one for the pixel
// above-right, then the four neighbours in turn through a single shared
// squared distance unit (left, up-left, up, up-right) that feeds the 40-bit
// sum. After the last pixel of a frame the unit works out the pair count and,
// when the sum is nonzero, runs a bit-per-cycle restoring divider for
// beta_q = floor(pairs * 2^39 / sum), then hands the result to the output
// register; the next frame starts as soon as that register is free. The result
// waits in its register while the next frame streams in. The line store needs
// no clearing pass after reset. A write to either size register restarts the
// frame; sizes of 0 act as 1 and sizes above 1024 act as 1024.
module neighbour_contrast_beta_unit import ncb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ncb_pixel_if.sink     pixel,
  ncb_result_if.source  result,
  ncb_cfg_if.sink       cfg
);

  localparam int CMP_W  = SIZE_W + 1;
  localparam int PROD_W = 2 * SIZE_W + 3;

  ncb_state_t state, state_next;
  ncb_nb_t    nb;

  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  logic [SUM_W-1:0]  dist_sum;
  logic [PIX_W-1:0]  left_pixel;
  logic [PIX_W-1:0]  upleft_pixel;
  logic [PIX_W-1:0]  up_pixel;
  logic [PIX_W-1:0]  upright_pixel;
  logic [PIX_W-1:0]  cur_pixel;
  logic [PIX_W-1:0]  rd_data;
  logic [PIX_W-1:0]  row_store [MAX_WIDTH];

  logic [SUM_W-1:0]     div_rem;
  logic [NUM_W-1:0]     div_num;
  logic [NUM_W-1:0]     div_quot;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic              out_valid;
  logic [BETA_W-1:0] out_beta;
  logic [SUM_W-1:0]  out_sum;
  logic [PAIR_W-1:0] out_pairs;
  logic              out_zero;

  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic              has_right;
  logic              y_last;
  logic              has_up;
  logic              has_left;
  logic              pix_accept;
  logic              cfg_write;
  logic              restart;
  logic              deliver;
  logic [COL_W-1:0]  rd_addr;
  logic              mem_we;
  logic [PIX_W-1:0]  nb_pixel;
  logic              nb_en;
  logic [SQ_W-1:0]   dist_val;
  logic [SUM_W:0]    sum_add;
  logic [SIZE_W-1:0] wm;
  logic [SIZE_W-1:0] hm;
  logic [PROD_W-1:0] pair_full;
  logic [SUM_W:0]    rem_sh;
  logic              rem_ge;

  function automatic logic [SQ_W-1:0] sq_dist(logic [PIX_W-1:0] p,
                                              logic [PIX_W-1:0] q);
    logic [CHAN_W-1:0]   a;
    logic [CHAN_W-1:0]   b;
    logic [CHAN_W-1:0]   d;
    logic [SQ_W-1:0]     acc;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      a = p[k*CHAN_W +: CHAN_W];
      b = q[k*CHAN_W +: CHAN_W];
      d = (a > b) ? a - b : b - a;
      acc = acc + SQ_W'(d) * SQ_W'(d);
    end
    return acc;
  endfunction

  assign w_eff = clamp_size(frame_width, SIZE_W'(MAX_WIDTH));
  assign h_eff = clamp_size(frame_height, SIZE_W'(MAX_HEIGHT));

  assign has_left  = (col_count != '0);
  assign has_up    = (row_count != '0);
  assign has_right = ((CMP_W'(col_count) + CMP_W'(1)) < CMP_W'(w_eff));
  assign y_last    = ((CMP_W'(row_count) + CMP_W'(1)) >= CMP_W'(h_eff));

  assign pixel.ready = (state == ST_IDLE) && !rst;
  assign cfg.ready   = !rst;
  assign pix_accept  = pixel.valid && pixel.ready;
  assign cfg_write   = cfg.valid && cfg.ready;
  assign restart     = cfg_write &&
                       ((cfg.index == CFG_FRAME_WIDTH) || (cfg.index == CFG_FRAME_HEIGHT));
  assign deliver     = (state == ST_DELIVER) && (!out_valid || result.ready);

  // ---------------- state register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = col_count;
    mem_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        rd_addr = col_count;
        if (pix_accept) begin
          state_next = ST_READ_UP;
        end
      end
      ST_READ_UP: begin
        rd_addr    = COL_W'(col_count + COL_W'(1));
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (nb == NB_UPRIGHT) begin
          mem_we = 1'b1;
          if (!has_right && y_last) begin
            state_next = ST_PAIRS;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PAIRS: begin
        state_next = (dist_sum == '0) ? ST_DELIVER : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_cnt == '0) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (deliver) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------- line store ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_store[col_count] <= cur_pixel;
    end
    rd_data <= row_store[rd_addr];
  end

  // ---------------- shared distance unit ----------------
  always_comb begin
    case (nb)
      NB_LEFT: begin
        nb_pixel = left_pixel;
        nb_en    = has_left;
      end
      NB_UPLEFT: begin
        nb_pixel = upleft_pixel;
        nb_en    = has_left && has_up;
      end
      NB_UP: begin
        nb_pixel = up_pixel;
        nb_en    = has_up;
      end
      NB_UPRIGHT: begin
        nb_pixel = upright_pixel;
        nb_en    = has_up && has_right;
      end
      default: begin
        nb_pixel = left_pixel;
        nb_en    = 1'b0;
      end
    endcase
  end

  assign dist_val = sq_dist(cur_pixel, nb_pixel);
  assign sum_add  = {1'b0, dist_sum} + (SUM_W + 1)'(dist_val);

  // ---------------- pair count and divider step ----------------
  assign wm        = w_eff - SIZE_W'(1);
  assign hm        = h_eff - SIZE_W'(1);
  assign pair_full = ((PROD_W'(wm) * PROD_W'(hm)) << 2) + PROD_W'(wm) + PROD_W'(hm);
  assign rem_sh    = {div_rem, div_num[NUM_W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, dist_sum});

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg.index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg.data;
        CFG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // ---------------- frame state ----------------
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      nb           <= NB_LEFT;
      col_count    <= '0;
      row_count    <= '0;
      dist_sum     <= '0;
      left_pixel   <= '0;
      upleft_pixel <= '0;
    end else begin
      case (state)
        ST_ACCUM: begin
          if (nb_en) begin
            dist_sum <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
          end
          nb <= ncb_nb_t'(nb + 2'd1);
          if (nb == NB_UPRIGHT) begin
            upleft_pixel <= up_pixel;
            left_pixel   <= cur_pixel;
            if (has_right) begin
              col_count <= COL_W'(col_count + COL_W'(1));
            end else begin
              col_count <= '0;
              row_count <= y_last ? '0 : ROW_W'(row_count + ROW_W'(1));
            end
          end
        end
        ST_DELIVER: begin
          if (deliver) begin
            dist_sum     <= '0;
            left_pixel   <= '0;
            upleft_pixel <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- pixel and neighbour capture ----------------
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      cur_pixel <= {pixel.chan_c, pixel.chan_b, pixel.chan_a};
    end
    if (state == ST_READ_UP) begin
      up_pixel <= rd_data;
    end
    // data read at the above-right address lands in the first accumulate cycle
    if ((state == ST_ACCUM) && (nb == NB_LEFT)) begin
      upright_pixel <= rd_data;
    end
  end

  // ---------------- divider ----------------
  always_ff @(posedge clk) begin
    if (state == ST_PAIRS) begin
      div_num   <= {pair_full[PAIR_W-1:0], FRAC_BITS'(0)};
      div_rem   <= '0;
      div_quot  <= '0;
      div_cnt   <= DIV_CNT_W'(NUM_W - 1);
    end else if (state == ST_DIVIDE) begin
      div_num  <= div_num << 1;
      div_rem  <= rem_ge ? SUM_W'(rem_sh - {1'b0, dist_sum}) : rem_sh[SUM_W-1:0];
      div_quot <= {div_quot[NUM_W-2:0], rem_ge};
      div_cnt  <= DIV_CNT_W'(div_cnt - DIV_CNT_W'(1));
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (deliver) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_beta  <= BETA_W'(div_quot);
      out_sum   <= dist_sum;
      out_pairs <= pair_full[PAIR_W-1:0];
      out_zero  <= (dist_sum == '0);
    end
  end

  assign result.valid         = out_valid;
  assign result.beta_q        = out_beta;
  assign result.sq_sum        = out_sum;
  assign result.pair_total    = out_pairs;
  assign result.zero_contrast = out_zero;

endmodule

FILE: hw/rtl/ncb_checker.sv
// ----------------------------------------------------------------------------
// ncb_checker
// port-level checks of the contrast unit, bound to the top level
// ----------------------------------------------------------------------------
`include "neighbour_contrast_beta_unit_macros.svh"

module ncb_checker import ncb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              pix_valid,
  input logic              pix_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [BETA_W-1:0] res_beta_q,
  input logic [SUM_W-1:0]  res_sq_sum,
  input logic              res_zero_contrast
);

  // one pixel in flight at a time
  `NCB_ASSERT_NEXT(a_pix_single, pix_valid && pix_ready, !pix_ready, "pixel ready after accept")
  `NCB_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_sq_sum), "result dropped while stalled")
  `NCB_ASSERT_NOW(a_zero_beta, res_valid && res_zero_contrast, res_beta_q == '0, "beta nonzero on zero contrast")
  `NCB_ASSERT_NOW(a_zero_flag, res_valid, res_zero_contrast == (res_sq_sum == '0), "zero flag disagrees with sum")

endmodule

bind neighbour_contrast_beta_unit ncb_checker u_ncb_checker (
  .clk               (clk),
  .rst               (rst),
  .pix_valid         (pixel.valid),
  .pix_ready         (pixel.ready),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .res_beta_q        (result.beta_q),
  .res_sq_sum        (result.sq_sum),
  .res_zero_contrast (result.zero_contrast)
);

FILE: tb/ncb_contrast_checker.sv
// ----------------------------------------------------------------------------
// ncb contrast checker
// watches the pixel, result and register channels of the contrast unit,
// tracks frame position, line store and squared-distance sum on its own,
// and compares every delivered frame result with the predicted one
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ncb_contrast_checker import ncb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  ncb_pixel_if  pixel,
  ncb_result_if result,
  ncb_cfg_if    cfg,
  output int    fail_count,
  output int    pending
);

  typedef struct packed {
    logic [BETA_W-1:0] beta_q;
    logic [SUM_W-1:0]  sq_sum;
    logic [PAIR_W-1:0] pair_total;
    logic              zero_contrast;
  } frame_result_t;

  frame_result_t     frame_results_due[$];
  logic [PIX_W-1:0]  prev_line [MAX_WIDTH];
  logic [PIX_W-1:0]  left_pix;
  logic [PIX_W-1:0]  upleft_pix;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  int unsigned       col;
  int unsigned       row;
  logic [SUM_W-1:0]  contrast_sum;
  int                errors;

  function automatic int unsigned active_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    int unsigned r;
    if (v == '0) begin
      r = 1;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] colour_dist(logic [PIX_W-1:0] p, logic [PIX_W-1:0] q);
    int          d;
    int unsigned k;
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (k = 0; k < 3; k++) begin
      d = int'(p[k*CHAN_W +: CHAN_W]) - int'(q[k*CHAN_W +: CHAN_W]);
      acc += SUM_W'(d * d);
    end
    return acc;
  endfunction

  // saturating accumulate into the 40-bit sum
  function automatic logic [SUM_W-1:0] sum_add(logic [SUM_W-1:0] acc, logic [SUM_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, acc} + {1'b0, v};
    return t[SUM_W] ? '1 : t[SUM_W-1:0];
  endfunction

  task automatic restart_frame();
    col          = 0;
    row          = 0;
    contrast_sum = '0;
    left_pix     = '0;
    upleft_pix   = '0;
  endtask

  always @(posedge clk) begin : predict_and_compare
    frame_result_t     want;
    frame_result_t     got;
    logic [PIX_W-1:0]  pix;
    logic [PIX_W-1:0]  above;
    int unsigned       w;
    int unsigned       h;
    int unsigned       x;
    int unsigned       y;
    longint unsigned   wm;
    longint unsigned   hm;
    longint unsigned   pairs;
    logic [127:0]      num;
    if (rst) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      restart_frame();
      frame_results_due.delete();
      errors     = 0;
      pending    <= 0;
      fail_count <= 0;
    end else begin
      // oldest expectation first, so a result and a new prediction can share a cycle
      if (result.valid && result.ready) begin
        got = '{result.beta_q, result.sq_sum, result.pair_total, result.zero_contrast};
        if (frame_results_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result with nothing expected: beta_q=%h sq_sum=%0d pairs=%0d zero=%b",
                     $realtime, got.beta_q, got.sq_sum, got.pair_total, got.zero_contrast);
          end
        end else begin
          want = frame_results_due.pop_front();
          if (got.beta_q !== want.beta_q || got.sq_sum !== want.sq_sum ||
              got.pair_total !== want.pair_total || got.zero_contrast !== want.zero_contrast) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected beta_q=%h sq_sum=%0d pairs=%0d zero=%b",
                       want.beta_q, want.sq_sum, want.pair_total, want.zero_contrast);
              $display("  actual   beta_q=%h sq_sum=%0d pairs=%0d zero=%b",
                       got.beta_q, got.sq_sum, got.pair_total, got.zero_contrast);
            end
          end
        end
      end

      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_FRAME_WIDTH) begin
          width_reg = cfg.data;
          restart_frame();
        end else if (cfg.index == CFG_FRAME_HEIGHT) begin
          height_reg = cfg.data;
          restart_frame();
        end
      end

      if (pixel.valid && pixel.ready) begin
        w = active_size(width_reg, MAX_WIDTH);
        h = active_size(height_reg, MAX_HEIGHT);
        x = (col >= w) ? w - 1 : col;
        y = (row >= h) ? h - 1 : row;
        pix   = {pixel.chan_c, pixel.chan_b, pixel.chan_a};
        above = prev_line[x];

        if (x > 0) contrast_sum = sum_add(contrast_sum, colour_dist(pix, left_pix));
        if (y > 0 && x > 0) contrast_sum = sum_add(contrast_sum, colour_dist(pix, upleft_pix));
        if (y > 0) contrast_sum = sum_add(contrast_sum, colour_dist(pix, above));
        if (y > 0 && x + 1 < w) begin
          contrast_sum = sum_add(contrast_sum, colour_dist(pix, prev_line[x + 1]));
        end

        upleft_pix   = above;
        left_pix     = pix;
        prev_line[x] = pix;

        if (x + 1 < w) begin
          col = x + 1;
          row = y;
        end else if (y + 1 < h) begin
          col = 0;
          row = y + 1;
        end else begin
          wm    = w - 1;
          hm    = h - 1;
          pairs = 4 * wm * hm + wm + hm;
          if (contrast_sum == '0) begin
            want.beta_q        = '0;
            want.zero_contrast = 1'b1;
          end else begin
            if (pairs / contrast_sum >= (64'd1 << 23)) begin
              want.beta_q = '1;
            end else begin
              num         = 128'(pairs) << FRAC_BITS;
              want.beta_q = BETA_W'(num / contrast_sum);
            end
            want.zero_contrast = 1'b0;
          end
          want.sq_sum     = contrast_sum;
          want.pair_total = PAIR_W'(pairs);
          frame_results_due = {frame_results_due, want};
          restart_frame();
        end
      end

      pending    <= frame_results_due.size();
      fail_count <= errors;
    end
  end

endmodule

FILE: tb/neighbour_contrast_beta_unit_tb.sv
// ----------------------------------------------------------------------------
// neighbour contrast beta unit testbench
// streams raster frames of many sizes into the unit with random gaps and
// back-pressure, including single-pixel, flat and full-width frames, and
// leaves prediction and comparison to the checker instantiated beside it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module neighbour_contrast_beta_unit_tb import ncb_pkg::*; ();

  localparam int RANDOM_ITEMS   = 540;
  localparam int SETTLE_CYCLES  = 100;
  localparam int PRESSURE_HOLD  = 300;
  localparam int IDLE_LIMIT     = 4000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_3 = CFG_IDX_W'(3);

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   sent_items;
  bit   src_lazy;
  bit   src_eager;
  bit   sink_lazy;
  bit   hold_req;
  int unsigned frame_w;
  int unsigned frame_h;

  ncb_pixel_if  pixel ();
  ncb_result_if result ();
  ncb_cfg_if    cfg ();

  neighbour_contrast_beta_unit dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .result (result),
    .cfg    (cfg)
  );

  ncb_contrast_checker contrast_chk (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .result     (result),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ends the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((pixel.valid && pixel.ready) || (result.valid && result.ready) ||
                 (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, stretches without stalls, one long hold-off
  initial begin : result_sink
    int n;
    result.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = PRESSURE_HOLD;
      end else begin
        if ($urandom_range(0, 39) == 0) sink_lazy = !sink_lazy;
        n = sink_lazy ? $urandom_range(0, 13) : 0;
      end
      if (n > 0) begin
        result.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!(result.valid && result.ready));
    end
  end

  // leaves cfg.valid high so back-to-back writes need no lowering in between
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
  endtask

  task automatic set_size(int unsigned wd, int unsigned ht);
    cfg_write(CFG_FRAME_WIDTH, SIZE_W'(wd));
    cfg_write(CFG_FRAME_HEIGHT, SIZE_W'(ht));
    cfg.valid <= 1'b0;
    frame_w = (wd == 0) ? 1 : (wd > MAX_WIDTH) ? MAX_WIDTH : wd;
    frame_h = (ht == 0) ? 1 : (ht > MAX_HEIGHT) ? MAX_HEIGHT : ht;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] p);
    int gap;
    if ($urandom_range(0, 49) == 0) src_lazy = !src_lazy;
    gap = (src_lazy && !src_eager) ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      pixel.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel.valid  <= 1'b1;
    pixel.chan_a <= p[CHAN_W-1:0];
    pixel.chan_b <= p[2*CHAN_W-1:CHAN_W];
    pixel.chan_c <= p[3*CHAN_W-1:2*CHAN_W];
    do @(posedge clk); while (!(pixel.valid && pixel.ready));
    sent_items++;
  endtask

  function automatic logic [PIX_W-1:0] draw_pixel(logic [PIX_W-1:0] base);
    logic [PIX_W-1:0] p;
    int               k;
    p = base;
    case ($urandom_range(0, 3))
      0: p = PIX_W'($urandom);
      1: begin
        for (k = 0; k < 3; k++) p[k*CHAN_W +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      // low-contrast neighbourhood around the frame's base colour
      2: begin
        for (k = 0; k < 3; k++) begin
          p[k*CHAN_W +: CHAN_W] = base[k*CHAN_W +: CHAN_W] ^ CHAN_W'($urandom_range(0, 3));
        end
      end
      default: p = base;
    endcase
    return p;
  endfunction

  // some frames are flat, giving a zero sum with nonzero pairs when the frame has more than one pixel
  task automatic send_frame(int unsigned count);
    logic [PIX_W-1:0] base;
    bit               flat;
    int unsigned      i;
    base = PIX_W'($urandom);
    flat = ($urandom_range(0, 7) == 0);
    for (i = 0; i < count; i++) send_pixel(flat ? base : draw_pixel(base));
  endtask

  // lets every expected result arrive and the unit go quiet
  task automatic settle();
    pixel.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned wd;
    int unsigned ht;
    int unsigned px;
    int          random_start;
    rst          <= 1'b1;
    pixel.valid  <= 1'b0;
    pixel.chan_a <= '0;
    pixel.chan_b <= '0;
    pixel.chan_c <= '0;
    cfg.valid    <= 1'b0;
    cfg.index    <= CFG_FRAME_WIDTH;
    cfg.data     <= '0;
    sent_items   = 0;
    src_lazy     = 1'b1;
    src_eager    = 1'b0;
    sink_lazy    = 1'b1;
    hold_req     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero sizes act as a single-pixel frame
    set_size(0, 0);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    settle();

    // full-swing channels, then a flat frame
    set_size(2, 2);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h00FF00);
    send_pixel(24'hFF00FF);
    repeat (4) send_pixel(24'h070707);
    settle();

    // partial frame dropped by a register write
    set_size(3, 3);
    send_pixel(24'hFF0000);
    send_pixel(24'h0000FF);
    settle();
    set_size(3, 3);
    cfg_write(CFG_IDX_SPARE_2, '1);
    cfg_write(CFG_IDX_SPARE_3, '0);
    cfg.valid <= 1'b0;
    send_frame(9);
    settle();

    // widest row, oversize width clamps to the maximum
    set_size(2047, 1);
    send_frame(frame_w * frame_h);
    settle();

    // tall single-column frame
    set_size(1, 200);
    send_frame(frame_w * frame_h);
    settle();

    // result register held off while pixels keep coming
    set_size(2, 2);
    src_eager = 1'b1;
    hold_req  = 1'b1;
    repeat (16) send_frame(4);
    src_eager = 1'b0;
    settle();

    random_start = sent_items;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      wd = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      ht = $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) wd = 0;
      if ($urandom_range(0, 19) == 0) ht = 0;
      set_size(wd, ht);
      px = frame_w * frame_h;
      repeat ($urandom_range(1, 4)) send_frame(px);
      if (px > 1 && $urandom_range(0, 2) == 0) send_frame($urandom_range(1, px - 1));
      settle();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
